>>> rtl/hcrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcrd_pkg
// Shared types, character codes and result kinds for the chunked decoder.
// ----------------------------------------------------------------------------
package hcrd_pkg;

    localparam int CHUNK_SIZE_BITS_DEF = 16;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DATA      = 2'd0;
    localparam kind_t KIND_OK        = 2'd1;
    localparam kind_t KIND_MALFORMED = 2'd2;
    localparam kind_t KIND_RESERVED  = 2'd3;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d.value = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d.value = 4'(b - 8'h41 + 8'd10);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d.value = 4'(b - 8'h61 + 8'd10);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

>>> rtl/http_chunked_response_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_response_decoder
// Checks an HTTP status line, skips headers, dechunks the body and reports
// a verdict on the last byte of each response.
// The input register loads when a byte is accepted; the result register loads
// that byte's result, if any, when it is processed, and a result stall can hold
// the byte in between. Throughput: one byte per cycle while the result side is
// not stalled, set by the single state update between the two registers.
// Reset: synchronous, active low; returns to status line start, both
// register stages empty.
// ----------------------------------------------------------------------------
module http_chunked_response_decoder
    import hcrd_pkg::*;
#(
    parameter int CHUNK_SIZE_BITS = CHUNK_SIZE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_data
    output logic [1:0] m_tuser    // [1:0] out_kind
);

    localparam int W = CHUNK_SIZE_BITS;

    localparam logic [3:0] PH_ST_PRE  = 4'd0;
    localparam logic [3:0] PH_ST_CODE = 4'd1;
    localparam logic [3:0] PH_ST_REST = 4'd2;
    localparam logic [3:0] PH_HDR     = 4'd3;
    localparam logic [3:0] PH_SZ      = 4'd4;
    localparam logic [3:0] PH_SZ_EXT  = 4'd5;
    localparam logic [3:0] PH_SZ_CR   = 4'd6;
    localparam logic [3:0] PH_DATA    = 4'd7;
    localparam logic [3:0] PH_TRAIL1  = 4'd8;
    localparam logic [3:0] PH_TRAIL2  = 4'd9;
    localparam logic [3:0] PH_ZTAIL   = 4'd10;
    localparam logic [3:0] PH_DONE    = 4'd11;
    localparam logic [3:0] PH_DRAIN   = 4'd12;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;

    logic [3:0]   phase_reg,      phase_next;
    logic [2:0]   pos_reg,        pos_next;
    logic [1:0]   hem_reg,        hem_next;
    logic [W-1:0] acc_reg,        acc_next;
    logic         seen_reg,       seen_next;
    logic [W-1:0] left_reg,       left_next;
    logic         bad_reg,        bad_next;

    logic         out_valid_reg,  out_valid_next;
    logic [7:0]   out_data_reg,   out_data_next;
    kind_t        out_kind_reg,   out_kind_next;

    logic         out_free;
    logic         proc;
    logic         emit;
    logic [W-1:0] left_dec;
    hex_digit_t   hd;

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign hd       = hex_decode(in_byte_reg);
    assign left_dec = left_reg - W'(1);

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        hem_next       = hem_reg;
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        left_next      = left_reg;
        bad_next       = bad_reg;
        emit           = 1'b0;

        unique case (phase_reg)
            PH_ST_PRE: begin
                if (in_byte_reg == CH_SP) begin
                    phase_next = PH_ST_CODE;
                    pos_next   = 3'd0;
                end else if (in_byte_reg == CH_LF && hem_reg == 2'd1) begin
                    bad_next   = 1'b1;
                    phase_next = PH_DRAIN;
                end else begin
                    hem_next = {1'b0, in_byte_reg == CH_CR};
                end
            end
            PH_ST_CODE: begin
                if (pos_reg < 3'd3) begin
                    if (in_byte_reg != ((pos_reg == 3'd0) ? CH_TWO : CH_ZERO)) begin
                        bad_next   = 1'b1;
                        phase_next = PH_DRAIN;
                    end else begin
                        pos_next = pos_reg + 3'd1;
                    end
                end else if (pos_reg == 3'd3) begin
                    if (in_byte_reg == CH_CR) begin
                        pos_next = 3'd4;
                    end else begin
                        phase_next = PH_ST_REST;
                        hem_next   = 2'd0;
                    end
                end else begin
                    if (in_byte_reg == CH_LF) begin
                        bad_next   = 1'b1;
                        phase_next = PH_DRAIN;
                    end else begin
                        phase_next = PH_ST_REST;
                        hem_next   = {1'b0, in_byte_reg == CH_CR};
                    end
                end
            end
            PH_ST_REST: begin
                if (in_byte_reg == CH_LF && hem_reg == 2'd1) begin
                    phase_next = PH_HDR;
                    hem_next   = 2'd0;
                end else begin
                    hem_next = {1'b0, in_byte_reg == CH_CR};
                end
            end
            PH_HDR: begin
                if (in_byte_reg == (hem_reg[0] ? CH_LF : CH_CR)) begin
                    if (hem_reg == 2'd3) begin
                        phase_next = PH_SZ;
                        hem_next   = 2'd0;
                        acc_next   = '0;
                        seen_next  = 1'b0;
                    end else begin
                        hem_next = hem_reg + 2'd1;
                    end
                end else begin
                    hem_next = {1'b0, in_byte_reg == CH_CR};
                end
            end
            PH_SZ: begin
                if (hd.valid) begin
                    if (acc_reg[W-1:W-4] != 4'd0) begin
                        bad_next   = 1'b1;
                        phase_next = PH_DRAIN;
                    end else begin
                        acc_next  = {acc_reg[W-5:0], hd.value};
                        seen_next = 1'b1;
                    end
                end else if (in_byte_reg == CH_SP) begin
                    if (!seen_reg) begin
                        bad_next   = 1'b1;
                        phase_next = PH_DRAIN;
                    end else begin
                        phase_next = PH_SZ_EXT;
                        hem_next   = 2'd0;
                    end
                end else if (in_byte_reg == CH_CR) begin
                    phase_next = PH_SZ_CR;
                end else begin
                    bad_next   = 1'b1;
                    phase_next = PH_DRAIN;
                end
            end
            PH_SZ_EXT, PH_SZ_CR: begin
                if ((phase_reg == PH_SZ_EXT && in_byte_reg == CH_LF && hem_reg == 2'd1) ||
                    (phase_reg == PH_SZ_CR && in_byte_reg == CH_LF)) begin
                    if (!seen_reg) begin
                        bad_next   = 1'b1;
                        phase_next = PH_DRAIN;
                    end else begin
                        if (acc_reg == '0) begin
                            phase_next = PH_ZTAIL;
                        end else begin
                            left_next  = acc_reg;
                            phase_next = PH_DATA;
                        end
                        acc_next  = '0;
                        seen_next = 1'b0;
                    end
                end else if (phase_reg == PH_SZ_EXT) begin
                    hem_next = {1'b0, in_byte_reg == CH_CR};
                end else begin
                    bad_next   = 1'b1;
                    phase_next = PH_DRAIN;
                end
            end
            PH_DATA: begin
                emit      = 1'b1;
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_TRAIL1;
                end
            end
            PH_TRAIL1: phase_next = PH_TRAIL2;
            PH_TRAIL2: begin
                phase_next = PH_SZ;
                acc_next   = '0;
                seen_next  = 1'b0;
            end
            PH_ZTAIL: phase_next = PH_DONE;
            default: ;
        endcase

        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;

        if (proc && in_last_reg) begin
            out_valid_next = 1'b1;
            out_data_next  = 8'd0;
            out_kind_next  = (phase_next == PH_DONE && !bad_next) ? KIND_OK : KIND_MALFORMED;
            phase_next     = PH_ST_PRE;
            pos_next       = 3'd0;
            hem_next       = 2'd0;
            acc_next       = '0;
            seen_next      = 1'b0;
            left_next      = '0;
            bad_next       = 1'b0;
        end else if (proc && emit) begin
            out_valid_next = 1'b1;
            out_data_next  = in_byte_reg;
            out_kind_next  = KIND_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_ST_PRE;
            pos_reg       <= 3'd0;
            hem_reg       <= 2'd0;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            left_reg      <= '0;
            bad_reg       <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (proc) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                hem_reg   <= hem_next;
                acc_reg   <= acc_next;
                seen_reg  <= seen_next;
                left_reg  <= left_next;
                bad_reg   <= bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != KIND_RESERVED)
        else $error("reserved result kind");

    a_verdict_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_DATA) |-> m_tdata == 8'd0)
        else $error("verdict carries nonzero data");

    a_bad_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        bad_reg |-> phase_reg == PH_DRAIN)
        else $error("malformed flag outside drain phase");

    a_data_nonzero_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> left_reg != '0)
        else $error("data phase with empty chunk count");

endmodule

>>> tb/hcrd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcrd_stream_checker
// Watches both stream channels of the chunked response decoder. Every
// accepted request is run through a local copy of the decoder state machine.
// Each accepted result is compared, field by field, with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module hcrd_stream_checker
    import hcrd_pkg::*;
#(
    parameter int SIZE_BITS = CHUNK_SIZE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_data
    input  logic [1:0] m_tuser,   // [1:0] out_kind
    output int         fail_count,
    output int         pending,
    output int         payload_count,
    output int         ok_count,
    output int         bad_count
);

    typedef enum logic [3:0] {
        PH_STATUS_PRE,
        PH_STATUS_CODE,
        PH_STATUS_REST,
        PH_HEADERS,
        PH_SIZE,
        PH_SIZE_EXT,
        PH_SIZE_CR,
        PH_PAYLOAD,
        PH_TRAIL1,
        PH_TRAIL2,
        PH_ZERO_TAIL,
        PH_DONE,
        PH_DRAIN
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } result_t;

    phase_t               phase;
    logic [2:0]           code_pos;
    logic [1:0]           crlf_cnt;
    logic [SIZE_BITS-1:0] size_acc;
    logic                 digit_seen;
    logic [SIZE_BITS-1:0] bytes_left;
    logic                 malformed;
    result_t              predicted_out[$];

    function automatic int digit_val(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'(8'h30);
        if (b >= "A" && b <= "F") return int'(b) - int'(8'h41) + 10;
        if (b >= "a" && b <= "f") return int'(b) - int'(8'h61) + 10;
        return -1;
    endfunction

    task clear_state();
        phase      = PH_STATUS_PRE;
        code_pos   = '0;
        crlf_cnt   = '0;
        size_acc   = '0;
        digit_seen = 1'b0;
        bytes_left = '0;
        malformed  = 1'b0;
    endtask

    task mark_malformed();
        malformed = 1'b1;
        phase     = PH_DRAIN;
    endtask

    task close_size_line();
        if (!digit_seen) begin
            mark_malformed();
        end else begin
            if (size_acc == '0) begin
                phase = PH_ZERO_TAIL;
            end else begin
                bytes_left = size_acc;
                phase      = PH_PAYLOAD;
            end
            size_acc   = '0;
            digit_seen = 1'b0;
        end
    endtask

    task dechunk_byte(input logic [7:0] b, input logic eor);
        logic    emit;
        int      dv;
        result_t r;
        emit = 1'b0;
        case (phase)
            PH_STATUS_PRE: begin
                if (b == CH_SP) begin
                    phase    = PH_STATUS_CODE;
                    code_pos = '0;
                end else if (b == CH_LF && crlf_cnt == 2'd1) begin
                    mark_malformed();
                end else begin
                    crlf_cnt = (b == CH_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_STATUS_CODE: begin
                if (code_pos < 3'd3) begin
                    if (b != ((code_pos == 3'd0) ? CH_TWO : CH_ZERO)) mark_malformed();
                    else code_pos = code_pos + 3'd1;
                end else if (code_pos == 3'd3) begin
                    if (b == CH_CR) begin
                        code_pos = 3'd4;
                    end else begin
                        phase    = PH_STATUS_REST;
                        crlf_cnt = 2'd0;
                    end
                end else begin
                    if (b == CH_LF) begin
                        mark_malformed();
                    end else begin
                        phase    = PH_STATUS_REST;
                        crlf_cnt = (b == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
            end
            PH_STATUS_REST: begin
                if (b == CH_LF && crlf_cnt == 2'd1) begin
                    phase    = PH_HEADERS;
                    crlf_cnt = 2'd0;
                end else begin
                    crlf_cnt = (b == CH_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_HEADERS: begin
                if (b == (crlf_cnt[0] ? CH_LF : CH_CR)) begin
                    if (crlf_cnt == 2'd3) begin
                        phase      = PH_SIZE;
                        crlf_cnt   = 2'd0;
                        size_acc   = '0;
                        digit_seen = 1'b0;
                    end else begin
                        crlf_cnt = crlf_cnt + 2'd1;
                    end
                end else begin
                    crlf_cnt = (b == CH_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_SIZE: begin
                dv = digit_val(b);
                if (dv >= 0) begin
                    if ((size_acc >> (SIZE_BITS - 4)) != '0) begin
                        mark_malformed();
                    end else begin
                        size_acc   = (size_acc << 4) | SIZE_BITS'(dv);
                        digit_seen = 1'b1;
                    end
                end else if (b == CH_SP) begin
                    if (!digit_seen) begin
                        mark_malformed();
                    end else begin
                        phase    = PH_SIZE_EXT;
                        crlf_cnt = 2'd0;
                    end
                end else if (b == CH_CR) begin
                    phase = PH_SIZE_CR;
                end else begin
                    mark_malformed();
                end
            end
            PH_SIZE_EXT: begin
                if (b == CH_LF && crlf_cnt == 2'd1) close_size_line();
                else crlf_cnt = (b == CH_CR) ? 2'd1 : 2'd0;
            end
            PH_SIZE_CR: begin
                if (b == CH_LF) close_size_line();
                else mark_malformed();
            end
            PH_PAYLOAD: begin
                emit       = 1'b1;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) phase = PH_TRAIL1;
            end
            PH_TRAIL1: phase = PH_TRAIL2;
            PH_TRAIL2: begin
                phase      = PH_SIZE;
                size_acc   = '0;
                digit_seen = 1'b0;
            end
            PH_ZERO_TAIL: phase = PH_DONE;
            default: ;
        endcase

        if (eor) begin
            if (phase == PH_DONE && !malformed) begin
                r.kind = KIND_OK;
                ok_count++;
            end else begin
                r.kind = KIND_MALFORMED;
                bad_count++;
            end
            r.data = 8'h00;
            predicted_out.push_back(r);
            clear_state();
        end else if (emit) begin
            r.kind = KIND_DATA;
            r.data = b;
            predicted_out.push_back(r);
            payload_count++;
        end
    endtask

    initial begin
        fail_count    = 0;
        pending       = 0;
        payload_count = 0;
        ok_count      = 0;
        bad_count     = 0;
        clear_state();
    end

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            clear_state();
            predicted_out.delete();
        end else begin
            if (s_tvalid && s_tready) dechunk_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (predicted_out.size() == 0) begin
                    $display("%0t: unexpected result kind %0d data %02h, none expected",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_out.pop_front();
                    if (m_tuser !== want.kind) begin
                        $display("%0t: kind mismatch: expected %0d, actual %0d",
                                 $time, want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== want.data) begin
                        $display("%0t: data mismatch: expected %02h, actual %02h",
                                 $time, want.data, m_tdata);
                        fail_count++;
                    end
                end
            end
        end
        pending = predicted_out.size();
    end

endmodule

>>> tb/tb_http_chunked_response_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_response_decoder
// Streams directed and random HTTP responses into the decoder with random
// gaps on the input side and random stalls on the result side, including
// one long result hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_http_chunked_response_decoder;
    import hcrd_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 100;
    localparam int DRAIN_LIMIT  = 5000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    int fail_count;
    int pending;
    int payload_count;
    int ok_count;
    int bad_count;

    logic [8:0] stim_q[$];
    int         press_idx;
    logic       tail_run;
    logic       hold_req;
    logic       hold_done;

    http_chunked_response_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hcrd_stream_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .payload_count (payload_count),
        .ok_count      (ok_count),
        .bad_count     (bad_count)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned pick_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned v);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic lst);
        stim_q.push_back({lst, b});
    endtask

    task automatic push_crlf();
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
    endtask

    // '~' expands to CR LF, '^' to a lone CR
    task automatic push_txt(input string s, input logic end_mark);
        for (int k = 0; k < s.len(); k++) begin
            if (s[k] == "~") push_crlf();
            else if (s[k] == "^") push_byte(CH_CR, 1'b0);
            else push_byte(s[k], 1'b0);
        end
        if (end_mark) stim_q[stim_q.size() - 1][8] = 1'b1;
    endtask

    task automatic push_size_line(input int unsigned sz);
        int nd;
        nd = (sz < 16) ? 1 : ((sz < 256) ? 2 : 3);
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) push_byte(CH_ZERO, 1'b0);
        for (int k = nd - 1; k >= 0; k--) push_byte(hex_char((sz >> (4 * k)) & 15), 1'b0);
        if ($urandom_range(0, 3) == 0) begin
            push_byte(CH_SP, 1'b0);
            repeat ($urandom_range(0, 5)) push_byte(text_byte(), 1'b0);
        end
        push_crlf();
    endtask

    task automatic push_good_response(input int unsigned max_chunk);
        int          nlines;
        int unsigned sz;
        if ($urandom_range(0, 1)) push_txt("HTTP/1.1", 1'b0);
        else repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(8'h21, 8'h7e)), 1'b0);
        push_txt(" 200", 1'b0);
        if ($urandom_range(0, 1)) push_txt(" OK", 1'b0);
        else repeat ($urandom_range(1, 6)) push_byte(text_byte(), 1'b0);
        push_crlf();
        nlines = $urandom_range(0, 3);
        if (nlines == 0) push_crlf();
        repeat (nlines) begin
            repeat ($urandom_range(1, 12)) push_byte(text_byte(), 1'b0);
            push_crlf();
        end
        push_crlf();
        repeat ($urandom_range(1, 3)) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, max_chunk)
                                             : $urandom_range(1, 8);
            push_size_line(sz);
            repeat (sz) push_byte(8'($urandom_range(0, 255)), 1'b0);
            repeat (2) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        push_size_line(0);
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        stim_q[stim_q.size() - 1][8] = 1'b1;
    endtask

    task automatic push_random_response();
        int          start;
        int          cut;
        int unsigned mode;
        start = stim_q.size();
        mode  = $urandom_range(0, 99);
        if (mode < 90) push_good_response(48);
        if (mode >= 60 && mode < 75) begin
            cut = $urandom_range(start, stim_q.size() - 1);
            stim_q[cut][7:0] = 8'($urandom_range(0, 255));
        end else if (mode >= 75 && mode < 90) begin
            cut = $urandom_range(start, stim_q.size() - 1);
            while (stim_q.size() > cut + 1) void'(stim_q.pop_back());
            stim_q[cut][8] = 1'b1;
        end else if (mode >= 90) begin
            repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            stim_q[stim_q.size() - 1][8] = 1'b1;
        end
    endtask

    task automatic build_stimulus();
        int dir_size;
        // accepted, with payload extremes
        push_txt(" 200x~~~1~A~0~z", 1'b1);
        push_txt(" 200x~~~2~", 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_txt("~0~z", 1'b1);
        // wrong status code, CRLF before the first space, nothing after the code
        push_txt(" 201x~", 1'b1);
        push_txt("ab~", 1'b1);
        push_txt(" 200~~~~0~z", 1'b1);
        // CR then other byte after the code, lowercase size with extension, trailing bytes
        push_txt(" 200^Z~h~~0a ;x~0123456789~0~tt", 1'b1);
        // empty size, space first, non-hex, lone CR, oversize
        push_txt(" 200x~~~~q", 1'b1);
        push_txt(" 200x~~~ 1~", 1'b1);
        push_txt(" 200x~~~g~", 1'b1);
        push_txt(" 200x~~~1^x", 1'b1);
        push_txt(" 200x~~~10000~", 1'b1);
        // largest size, then end mark on a payload byte
        push_txt(" 200x~~~FFFF~abc", 1'b1);
        // end mark on the zero chunk's LF, on the first byte, inside headers
        push_txt(" 200x~~~0~", 1'b1);
        push_txt("x", 1'b1);
        push_txt(" 200x~h", 1'b1);

        press_idx = stim_q.size();
        push_txt(" 200 OK~~~40~", 1'b0);
        repeat (64) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_txt("~0~z", 1'b1);

        dir_size = stim_q.size();
        while (stim_q.size() < dir_size + RANDOM_ITEMS) push_random_response();
    endtask

    initial begin
        int unsigned gap_pct;
        int          n;
        int          waited;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        tail_run  = 1'b0;
        hold_req  = 1'b0;
        build_stimulus();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        gap_pct = 20;
        for (int i = 0; i < stim_q.size(); i++) begin
            tail_run = (i + TAIL_ITEMS >= stim_q.size());
            if (i == press_idx) hold_req = 1'b1;
            if (!tail_run && $urandom_range(0, 99) < gap_pct) begin
                n = $urandom_range(1, 4);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tdata  <= stim_q[i][7:0];
            s_tlast  <= stim_q[i][8];
            do @(posedge aclk); while (!s_tready);
            if (stim_q[i][8]) gap_pct = pick_rate();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (8) @(negedge aclk);

        if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
        $display("Run covered %0d requests in %0d responses: %0d accepted, %0d malformed.",
                 stim_q.size(), ok_count + bad_count, ok_count, bad_count);
        $display("%0d payload bytes compared; one result hold-off of %0d cycles applied.",
                 payload_count, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int unsigned stall_pct;
        int          n;
        int          cyc;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        stall_pct = 20;
        cyc       = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 300 == 0) stall_pct = pick_rate();
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready  <= 1'b1;
                hold_done = 1'b1;
            end else if (!tail_run && $urandom_range(0, 99) < stall_pct) begin
                n = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> http_chunked_response_decoder.f
rtl/hcrd_pkg.sv
rtl/http_chunked_response_decoder.sv
tb/hcrd_stream_checker.sv
tb/tb_http_chunked_response_decoder.sv
